[rtl/core/wn255_pkg.sv]
// Shared constants for the weight normalize-to-255 unit.
// No dependencies; imported by the unit and its checker.
package wn255_pkg;

   // Bits in one packed weight lane.
   localparam int LaneBits = 8;
   // Width of the packed weight and result words.
   localparam int WordBits = 32;
   // Lanes that fit in one packed word.
   localparam int WordLanes = WordBits / LaneBits;
   // Default lane count of the unit.
   localparam int DefaultLanes = 4;
   // Target sum of the normalized lanes.
   localparam logic [LaneBits-1:0] FullScale = 8'd255;

endpackage

[rtl/core/weight_normalize_to_255_unit.sv]
// Weight normalize-to-255 unit: largest-remainder apportionment of packed weights.
// Depends on wn255_pkg for lane widths and the full-scale constant.

// One beat on req_ carries LANES packed 8-bit weights. The result beat on rsp_ holds
// the weights rescaled to sum to exactly 255: each lane gets floor(w*255/sum), and the
// leftover units go one at a time to the lane with the largest remainder (lowest lane
// on a tie). An all-zero beat returns 255 in lane 0 and raises rsp_tuser. Lanes beyond
// bit 31 read as zero and are not returned. The unit handles one beat at a time with
// one shared adder/compare-subtract datapath: it sums the weights lane by lane, runs a
// bit-serial divide for each lane, then scans all lanes once for each leftover unit.
// req_tready is high only while the unit is idle; a finished result waits in the output
// register without blocking the next request beat, and the following result then waits
// until the register is free.
module weight_normalize_to_255_unit #(
   parameter int LANES = wn255_pkg::DefaultLanes
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: weight_vector[31:0]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wn255_pkg::WordBits-1:0] req_tdata,
   // rsp_tdata: normalized_vector[31:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wn255_pkg::WordBits-1:0] rsp_tdata,
   // rsp_tuser: zero_sum[0]
   output logic                           rsp_tuser
);
   import wn255_pkg::*;

   localparam int LaneW = $clog2(LANES);
   localparam int SumW  = $clog2(255 * LANES + 1);
   localparam int PadW  = (LaneBits * LANES > WordBits) ? LaneBits * LANES : WordBits;
   localparam int ProdW = 2 * LaneBits;
   localparam int StepW = $clog2(LaneBits);
   localparam int OutLanes = (LANES < WordLanes) ? LANES : WordLanes;

   localparam logic [2:0] StIdle     = 3'd0;
   localparam logic [2:0] StSum      = 3'd1;
   localparam logic [2:0] StDivLoad  = 3'd2;
   localparam logic [2:0] StDiv      = 3'd3;
   localparam logic [2:0] StPassInit = 3'd4;
   localparam logic [2:0] StScan     = 3'd5;
   localparam logic [2:0] StFinish   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [WordBits-1:0]  word_ff, word_in;
   logic [LaneW-1:0]     lane_ff, lane_in;
   logic [SumW-1:0]      sum_ff, sum_in;
   logic [SumW-1:0]      part_ff, part_in;
   logic [LaneBits-1:0]  low_ff, low_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [LaneBits-1:0]  total_ff, total_in;
   logic                 zero_ff, zero_in;
   logic [LaneW-1:0]     best_ff, best_in;
   logic [SumW-1:0]      best_rem_ff, best_rem_in;
   logic [LaneBits-1:0]  quot_ff [LANES];
   logic [LaneBits-1:0]  quot_in [LANES];
   logic [SumW-1:0]      rem_ff [LANES];
   logic [SumW-1:0]      rem_in [LANES];
   logic [LANES-1:0]     bonus_ff, bonus_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WordBits-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic [PadW-1:0]      padded;
   logic [LaneBits-1:0]  lane_w;
   logic [ProdW-1:0]     product;
   logic [SumW:0]        trial;
   logic                 trial_ge;
   logic [SumW-1:0]      trial_rem;
   logic                 lane_last;
   logic                 scan_win;
   logic [LaneW-1:0]     award_lane;
   logic [SumW-1:0]      sum_next;
   logic [WordBits-1:0]  packed_out;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Select the current lane's weight; lanes past the word read as zero
   assign padded    = PadW'(word_ff);
   assign lane_w    = padded[LaneBits * lane_ff +: LaneBits];
   assign lane_last = (lane_ff == LaneW'(LANES - 1));
   assign sum_next  = sum_ff + SumW'(lane_w);

   // w*255 as a shift and subtract
   assign product = {lane_w, {LaneBits{1'b0}}} - ProdW'(lane_w);

   // Shared compare-subtract: one quotient bit per cycle
   assign trial     = {part_ff, low_ff[LaneBits-1]};
   assign trial_ge  = (trial >= {1'b0, sum_ff});
   assign trial_rem = trial_ge ? SumW'(trial - {1'b0, sum_ff}) : trial[SumW-1:0];

   // Largest-remainder scan; strict compare keeps the lowest lane on a tie
   assign scan_win   = (rem_ff[lane_ff] > best_rem_ff);
   assign award_lane = scan_win ? lane_ff : best_ff;

   // Pack the result lanes that fit in the output word
   always_comb begin
      packed_out = '0;
      for (int i = 0; i < OutLanes; i++) begin
         packed_out[LaneBits * i +: LaneBits] = quot_ff[i] + LaneBits'(bonus_ff[i]);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      lane_in      = lane_ff;
      sum_in       = sum_ff;
      part_in      = part_ff;
      low_in       = low_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      zero_in      = zero_ff;
      best_in      = best_ff;
      best_rem_in  = best_rem_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bonus_in     = bonus_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // Drop the result once the beat is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               word_in  = req_tdata;
               lane_in  = '0;
               sum_in   = '0;
               total_in = '0;
               bonus_in = '0;
               state_in = StSum;
            end
         end
         StSum: begin
            sum_in = sum_next;
            if (lane_last) begin
               lane_in = '0;
               if (sum_next == '0) begin
                  zero_in  = 1'b1;
                  state_in = StFinish;
               end else begin
                  zero_in  = 1'b0;
                  state_in = StDivLoad;
               end
            end else begin
               lane_in = lane_ff + 1'b1;
            end
         end
         StDivLoad: begin
            part_in  = SumW'(product[ProdW-1:LaneBits]);
            low_in   = product[LaneBits-1:0];
            step_in  = '0;
            state_in = StDiv;
         end
         StDiv: begin
            part_in = trial_rem;
            low_in  = {low_ff[LaneBits-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(LaneBits - 1)) begin
               quot_in[lane_ff] = {low_ff[LaneBits-2:0], trial_ge};
               rem_in[lane_ff]  = trial_rem;
               total_in         = total_ff + {low_ff[LaneBits-2:0], trial_ge};
               if (lane_last) begin
                  state_in = StPassInit;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = StDivLoad;
               end
            end
         end
         StPassInit: begin
            if (total_ff == FullScale) begin
               state_in = StFinish;
            end else begin
               best_in     = '0;
               best_rem_in = rem_ff[0];
               lane_in     = LaneW'(1);
               state_in    = StScan;
            end
         end
         StScan: begin
            if (scan_win) begin
               best_in     = lane_ff;
               best_rem_in = rem_ff[lane_ff];
            end
            if (lane_last) begin
               // Award one unit and clear the winner's remainder
               bonus_in[award_lane] = 1'b1;
               rem_in[award_lane]   = '0;
               total_in             = total_ff + 1'b1;
               state_in             = StPassInit;
            end else begin
               lane_in = lane_ff + 1'b1;
            end
         end
         StFinish: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = zero_ff;
               rsp_data_in  = zero_ff ? WordBits'(FullScale) : packed_out;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      lane_ff     <= lane_in;
      sum_ff      <= sum_in;
      part_ff     <= part_in;
      low_ff      <= low_in;
      step_ff     <= step_in;
      total_ff    <= total_in;
      zero_ff     <= zero_in;
      best_ff     <= best_in;
      best_rem_ff <= best_rem_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      bonus_ff    <= bonus_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

[rtl/core/wn255_checker.sv]
// Port-level checker for the weight normalize-to-255 unit, with its bind.
// Depends on wn255_pkg for the word width and full-scale constant.
module wn255_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [wn255_pkg::WordBits-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [wn255_pkg::WordBits-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import wn255_pkg::*;

   logic [LaneBits+1:0] lane_total;

   assign lane_total = {2'b00, rsp_tdata[7:0]} + {2'b00, rsp_tdata[15:8]}
                     + {2'b00, rsp_tdata[23:16]} + {2'b00, rsp_tdata[31:24]};

   // A normalized beat always sums to full scale
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lane_total == (LaneBits + 2)'(FullScale)))
      else $error("result lanes do not sum to full scale");

   // An all-zero flag carries the default vector
   a_zero_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == WordBits'(FullScale)))
      else $error("zero_sum beat without default vector");

   // Busy after taking a request beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while still busy");

   // Hold a waiting request beat
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))
      else $error("waiting request beat changed");

   // Hold a stalled result beat
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind weight_normalize_to_255_unit wn255_checker u_wn255_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/tb_weight_normalize_to_255_unit.sv]
// Testbench for weight_normalize_to_255_unit: directed and random weight vectors are
// scored against an in-bench largest-remainder predictor, with random stalls on both sides.
// Depends on wn255_pkg and the unit RTL only.
module tb_weight_normalize_to_255_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import wn255_pkg::*;

   localparam int Lanes = DefaultLanes;
   localparam int ResetCycles = 9;
   localparam int SettleCycles = 100;
   localparam int CycleLimit = 500000;
   localparam int MaxReports = 10;
   localparam int RandomBeats = 400;
   localparam int SegmentBeats = 50;

   // One expected result beat.
   typedef struct {
      logic [WordBits-1:0] normalized;
      logic                zero_sum;
   } scaled_weights_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid;
   logic                req_tready;
   logic [WordBits-1:0] req_tdata;    // weight_vector[31:0]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [WordBits-1:0] rsp_tdata;    // normalized_vector[31:0]
   logic                rsp_tuser;    // zero_sum[0]

   scaled_weights_type expected_weights[$];
   int                 failure_count = 0;
   int                 report_count = 0;
   int                 cycle_count = 0;
   int                 sender_gap_max = 15;
   int                 receiver_stall_max = 15;
   int                 rsp_hold_cycles = 0;

   weight_normalize_to_255_unit #(
      .LANES(Lanes)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apportion 255 units over the lanes by largest remainder.
   function automatic scaled_weights_type normalize_weights(
      input logic [WordBits-1:0] weights
   );
      int unsigned        share[Lanes];
      int unsigned        remainder[Lanes];
      int unsigned        weight_sum;
      int unsigned        allotted;
      int unsigned        product;
      int                 best;
      scaled_weights_type result;
      weight_sum = 0;
      allotted = 0;
      result.normalized = '0;
      result.zero_sum = 1'b0;
      for (int i = 0; i < Lanes; i++) begin
         share[i] = (i < WordLanes) ? int'(weights[i*LaneBits +: LaneBits]) : 0;
         weight_sum += share[i];
      end
      if (weight_sum == 0) begin
         result.normalized[LaneBits-1:0] = FullScale;
         result.zero_sum = 1'b1;
         return result;
      end
      for (int i = 0; i < Lanes; i++) begin
         product = share[i] * int'(FullScale);
         share[i] = product / weight_sum;
         remainder[i] = product % weight_sum;
         allotted += share[i];
      end
      // Hand out leftover units; the lowest lane wins a tie, the winner's remainder clears.
      for (int pass = 0; pass < Lanes && allotted < int'(FullScale); pass++) begin
         best = 0;
         for (int i = 1; i < Lanes; i++) begin
            if (remainder[i] > remainder[best]) begin
               best = i;
            end
         end
         share[best] += 1;
         remainder[best] = 0;
         allotted += 1;
      end
      for (int i = 0; i < Lanes && i < WordLanes; i++) begin
         result.normalized[i*LaneBits +: LaneBits] = share[i][LaneBits-1:0];
      end
      return result;
   endfunction

   function automatic int draw_wait(input int max_wait);
      return (max_wait == 0) ? 0 : int'($urandom_range(max_wait, 0));
   endfunction

   // Offer one weight beat after a random gap and hold it until accepted.
   task automatic send_weights(input logic [WordBits-1:0] weights);
      int gap;
      gap = draw_wait(sender_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= weights;
      do @(posedge clock); while (!req_tready);
      expected_weights.push_back(normalize_weights(weights));
   endtask

   // Drop valid and wait until every expected beat has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
   endtask

   task automatic test_zero_vector();
      send_weights('0);
   endtask

   // One nonzero lane takes all 255 units.
   task automatic test_single_lane();
      for (int lane = 0; lane < WordLanes; lane++) begin
         send_weights(32'h0000_0001 << (lane * LaneBits));
         send_weights(32'h0000_00FF << (lane * LaneBits));
      end
   endtask

   // Equal remainders and the most leftover units.
   task automatic test_remainder_ties();
      send_weights(32'h0101_0101);
      send_weights(32'h0001_0101);
      send_weights(32'hFF01_0101);
      send_weights(32'h0302_0201);
      send_weights(32'h0100_0001);
      send_weights(32'h0707_0303);
   endtask

   task automatic test_extremes();
      send_weights(32'hFFFF_FFFF);
      send_weights(32'h8080_8080);
      send_weights(32'hFEFE_FEFF);
      send_weights(32'h01FF_01FF);
      send_weights(32'h7F80_817F);
      wait_drained();
   endtask

   // Hold the result side while the sender keeps offering, so the unit stalls its input.
   task automatic test_output_backpressure();
      sender_gap_max = 0;
      rsp_hold_cycles = 400;
      for (int n = 0; n < 8; n++) begin
         send_weights($urandom);
      end
      wait_drained();
   endtask

   function automatic logic [WordBits-1:0] random_weights();
      logic [WordBits-1:0] weights;
      weights = $urandom;
      for (int lane = 0; lane < WordLanes; lane++) begin
         case ($urandom_range(3, 0))
            0: ;
            1: weights[lane*LaneBits +: LaneBits] = $urandom_range(1, 0) ? 8'd0
                                                   : weights[lane*LaneBits +: LaneBits];
            2: weights[lane*LaneBits +: LaneBits] = LaneBits'($urandom_range(3, 0));
            default: weights[lane*LaneBits +: LaneBits] = LaneBits'($urandom_range(255, 200));
         endcase
      end
      return weights;
   endfunction

   // Random traffic in segments, each with its own idle profile.
   task automatic test_random_traffic();
      int profile[3] = '{0, 3, 15};
      for (int n = 0; n < RandomBeats; n++) begin
         if (n % SegmentBeats == 0) begin
            sender_gap_max = profile[$urandom_range(2, 0)];
            receiver_stall_max = profile[$urandom_range(2, 0)];
         end
         if ($urandom_range(31, 0) == 0) begin
            send_weights('0);
         end else begin
            send_weights(random_weights());
         end
      end
      wait_drained();
   endtask

   // Receiver: random stalls per beat, plus any requested long hold-off.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = rsp_hold_cycles + draw_wait(receiver_stall_max);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && rsp_hold_cycles == 0);
      end
   end

   // Score each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      scaled_weights_type oldest;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_weights.size() == 0) begin
            failure_count++;
            if (report_count < MaxReports) begin
               report_count++;
               $display("unexpected result beat: data=%h zero_sum=%b", rsp_tdata, rsp_tuser);
            end
         end else begin
            oldest = expected_weights.pop_front();
            if (rsp_tdata !== oldest.normalized || rsp_tuser !== oldest.zero_sum) begin
               failure_count++;
               if (report_count < MaxReports) begin
                  report_count++;
                  $display("result mismatch: expected data=%h zero_sum=%b",
                           oldest.normalized, oldest.zero_sum);
                  $display("                 got data=%h zero_sum=%b",
                           rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_vector();
      test_single_lane();
      test_remainder_ties();
      test_extremes();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (failure_count == 0 && expected_weights.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
